[rtl/bpe_pkg.sv]
`timescale 1ns / 1ps

package bpe_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_PUSH   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Fixed field widths of the stream payloads.
  localparam int OP_W     = 2;
  localparam int RIDX_W   = 12;
  localparam int FID_W    = 16;
  localparam int CNT_CFG_W = 13;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 16;
  localparam int M_USER_W = 2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RULE_RD,
    ST_RULE_LD,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

[rtl/bpe_rule_table.sv]
`timescale 1ns / 1ps

module bpe_rule_table import bpe_pkg::*; #(
  parameter int MAX_RULES = 4096,
  parameter int ID_BITS   = 16,
  parameter int RA_W      = 12
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [RIDX_W-1:0]   wr_idx,
  input  logic [ID_BITS-1:0]  wr_left,
  input  logic [ID_BITS-1:0]  wr_right,
  input  logic [ID_BITS-1:0]  wr_merged,
  input  logic [RA_W-1:0]     rd_addr,
  output logic [ID_BITS-1:0]  rd_left,
  output logic [ID_BITS-1:0]  rd_right,
  output logic [ID_BITS-1:0]  rd_merged
);

  logic [ID_BITS-1:0] left_mem   [MAX_RULES];
  logic [ID_BITS-1:0] right_mem  [MAX_RULES];
  logic [ID_BITS-1:0] merged_mem [MAX_RULES];
  logic               in_range;

  // Loads beyond the table are ignored.
  assign in_range = 32'(wr_idx) < MAX_RULES;

  // Write port for rule loads.
  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      left_mem[RA_W'(wr_idx)]   <= wr_left;
      right_mem[RA_W'(wr_idx)]  <= wr_right;
      merged_mem[RA_W'(wr_idx)] <= wr_merged;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_left   <= left_mem[rd_addr];
    rd_right  <= right_mem[rd_addr];
    rd_merged <= merged_mem[rd_addr];
  end

endmodule

[rtl/bpe_merge_applier_core.sv]
`timescale 1ns / 1ps
// Load and push beats are taken one per cycle while the block is idle.
// A finish beat runs each configured rule as one compaction pass over the symbol memory:
// a rule read, a first-symbol load, a scan step per later symbol and a write-back.
// Each result beat then takes a symbol memory read state and an output state.
// Synchronous reset clears the sequencer, symbol count, drop flag and rule count.

module bpe_merge_applier_core import bpe_pkg::*; #(
  parameter int MAX_SYMBOLS = 64,
  parameter int MAX_RULES   = 4096,
  parameter int ID_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // rule_index, left_id, right_id, merged_id, symbol_id, zero pad
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // token_out
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  output logic                  m_axis_tlast,
  // empty_res, overflow
  output logic [M_USER_W-1:0]   m_axis_tuser,
  input  logic                  cfg_we,
  input  logic [CNT_CFG_W-1:0]  cfg_wdata
);

  localparam int AW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW   = $clog2(MAX_SYMBOLS + 1);
  localparam int RA_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RCW  = $clog2(MAX_RULES + 1);

  state_t               state, state_next;
  logic [CNT_CFG_W-1:0] rule_count;
  logic [RCW-1:0]       n_sat;
  logic [RCW-1:0]       r;
  logic [CW-1:0]        cnt, w, rd, e;
  logic                 flag;
  logic [ID_BITS-1:0]   held;
  logic [ID_BITS-1:0]   sym_mem [MAX_SYMBOLS];
  logic [ID_BITS-1:0]   sym_q;
  logic [AW-1:0]        sym_raddr;
  logic                 sym_we;
  logic [AW-1:0]        sym_waddr;
  logic [ID_BITS-1:0]   sym_wdata;
  logic [ID_BITS-1:0]   lft, rgt, mrg;
  logic                 accept, is_push, is_finish, match, out_last, out_empty;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_push   = s_axis_tuser == OP_PUSH;
  assign is_finish = s_axis_tuser == OP_FINISH;
  assign match     = (held == lft) && (sym_q == rgt);
  assign out_empty = cnt == '0;
  assign out_last  = out_empty || ((e + CW'(1)) == cnt);

  // Rule count saturates at the table depth.
  assign n_sat = (32'(rule_count) > MAX_RULES) ? RCW'(MAX_RULES) : RCW'(rule_count);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
    end else if (cfg_we) begin
      rule_count <= cfg_wdata;
    end
  end

  // Rule table.
  bpe_rule_table #(
    .MAX_RULES (MAX_RULES),
    .ID_BITS   (ID_BITS),
    .RA_W      (RA_W)
  ) u_rules (
    .clk       (clk),
    .wr_en     (accept && (s_axis_tuser == OP_LOAD)),
    .wr_idx    (s_axis_tdata[11:0]),
    .wr_left   (ID_BITS'(s_axis_tdata[27:12])),
    .wr_right  (ID_BITS'(s_axis_tdata[43:28])),
    .wr_merged (ID_BITS'(s_axis_tdata[59:44])),
    .rd_addr   (RA_W'(r)),
    .rd_left   (lft),
    .rd_right  (rgt),
    .rd_merged (mrg)
  );

  // Symbol memory read address; the emit address is held while a beat waits.
  always_comb begin
    case (state) inside
      ST_RULE_LD:              sym_raddr = AW'(1);
      ST_SCAN:                 sym_raddr = AW'(rd + CW'(1));
      ST_EMIT_RD, ST_EMIT_OUT: sym_raddr = e[AW-1:0];
      default:                 sym_raddr = '0;
    endcase
  end

  // Symbol memory write port: pushes, compacted symbols and the final held one.
  always_comb begin
    sym_we    = 1'b0;
    sym_waddr = w[AW-1:0];
    sym_wdata = held;
    if (state == ST_IDLE) begin
      sym_we    = accept && is_push && (cnt < CW'(MAX_SYMBOLS));
      sym_waddr = cnt[AW-1:0];
      sym_wdata = ID_BITS'(s_axis_tdata[75:60]);
    end else if (state == ST_SCAN) begin
      sym_we = !match;
    end else if (state == ST_FLUSH) begin
      sym_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    sym_q <= sym_mem[sym_raddr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_finish) begin
          state_next = (cnt < CW'(2) || n_sat == '0) ? ST_EMIT_RD : ST_RULE_RD;
        end
      end
      ST_RULE_RD: state_next = ST_RULE_LD;
      ST_RULE_LD: state_next = ST_SCAN;
      ST_SCAN: begin
        if ((rd + CW'(1)) == cnt) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_next = ((r + RCW'(1)) == n_sat || w == '0) ? ST_EMIT_RD : ST_RULE_RD;
      end
      ST_EMIT_RD: state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (m_axis_tready) state_next = out_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and result outputs.
  always_comb begin
    s_axis_tready = state == ST_IDLE;
    m_axis_tvalid = state == ST_EMIT_OUT;
    m_axis_tdata  = out_empty ? '0 : M_DATA_W'(sym_q);
    m_axis_tlast  = out_last;
    m_axis_tuser  = {flag, out_empty};
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      flag  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (accept && is_push) begin
            if (cnt < CW'(MAX_SYMBOLS)) cnt <= cnt + CW'(1);
            else flag <= 1'b1;
          end
          if (accept && is_finish) begin
            r <= '0;
            e <= '0;
          end
        end
        ST_RULE_LD: begin
          held <= sym_q;
          rd   <= CW'(1);
          w    <= '0;
        end
        ST_SCAN: begin
          if (match) begin
            held <= mrg;
          end else begin
            held <= sym_q;
            w    <= w + CW'(1);
          end
          rd <= rd + CW'(1);
        end
        ST_FLUSH: begin
          cnt <= w + CW'(1);
          r   <= r + RCW'(1);
        end
        ST_EMIT_OUT: begin
          if (m_axis_tready) begin
            e <= e + CW'(1);
            if (out_last) begin
              cnt  <= '0;
              flag <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The symbol count never exceeds the buffer depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SYMBOLS)) else $error("symbol count out of range");

  // Compaction never writes ahead of the read point.
  a_write_behind: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> w < rd) else $error("write index passed read index");

  // Input and output sides are never open together.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken during emit");

  // The last beat empties the buffer and clears the drop flag.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> cnt == '0 && !flag)
    else $error("buffer not cleared after finish");

endmodule
